[sv/kwm_pkg.sv]
// Package for the k-way sorted run merge block.
// Holds the key width, the default geometry and the result struct.
// No dependencies.
`default_nettype none

package kwm_pkg;

    localparam int KEY_W          = 32;
    localparam int NUM_RUNS_DEF   = 8;
    localparam int RUN_LENGTH_DEF = 8;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [KEY_W-1:0] key;
    } kwm_emit_t;

endpackage

`default_nettype wire

[sv/kwm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/kwm_cmp.sv]
// Shared signed key comparator for the merge scan.
// Depends on kwm_pkg.
`default_nettype none

module kwm_cmp
    import kwm_pkg::*;
(
    input  wire logic             cand_valid,
    input  wire logic [KEY_W-1:0] cand_key,
    input  wire logic             best_found,
    input  wire logic [KEY_W-1:0] best_key,
    output logic                  take
);

    logic less;

    assign less = $signed(cand_key) < $signed(best_key);
    assign take = cand_valid && (!best_found || less);

endmodule

`default_nettype wire

[sv/kwm_seq.sv]
// Load and merge sequencer: key store addressing, run heads and scan loop.
// Depends on kwm_pkg and kwm_cmp.
`default_nettype none

module kwm_seq
    import kwm_pkg::*;
#(
    parameter int NUM_RUNS   = NUM_RUNS_DEF,
    parameter int RUN_LENGTH = RUN_LENGTH_DEF,
    localparam int TOTAL     = NUM_RUNS * RUN_LENGTH,
    localparam int ADDR_W    = $clog2(TOTAL)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [KEY_W-1:0]  in_key,
    output logic                   ram_we,
    output logic      [ADDR_W-1:0] ram_waddr,
    output logic      [KEY_W-1:0]  ram_wdata,
    output logic      [ADDR_W-1:0] ram_raddr,
    input  wire logic [KEY_W-1:0]  ram_rdata,
    input  wire logic              out_free,
    output kwm_emit_t              emit
);

    localparam int RUN_W  = $clog2(NUM_RUNS);
    localparam int HEAD_W = $clog2(RUN_LENGTH + 1);

    typedef enum logic [1:0] {S_LOAD, S_SCAN, S_LAST, S_EMIT} state_t;

    state_t             state_reg,    state_next;
    logic [ADDR_W-1:0]  load_cnt_reg, load_cnt_next;
    logic [ADDR_W-1:0]  emit_cnt_reg, emit_cnt_next;
    logic [RUN_W-1:0]   scan_reg,     scan_next;
    logic               rd_pend_reg,  rd_pend_next;
    logic [RUN_W-1:0]   rd_run_reg,   rd_run_next;
    logic [HEAD_W-1:0]  rd_head_reg,  rd_head_next;
    logic               found_reg,    found_next;
    logic [KEY_W-1:0]   best_key_reg, best_key_next;
    logic [RUN_W-1:0]   best_run_reg, best_run_next;
    logic [HEAD_W-1:0]  best_head_reg, best_head_next;
    logic [HEAD_W-1:0]  head_reg  [NUM_RUNS];
    logic [HEAD_W-1:0]  head_next [NUM_RUNS];

    logic              take;
    logic              active;
    logic [HEAD_W-1:0] scan_head;
    logic              in_fire;
    logic              last_emit;

    kwm_cmp u_cmp (
        .cand_valid (rd_pend_reg),
        .cand_key   (ram_rdata),
        .best_found (found_reg),
        .best_key   (best_key_reg),
        .take       (take)
    );

    assign scan_head = head_reg[scan_reg];
    assign active    = scan_head < HEAD_W'(RUN_LENGTH);
    assign ram_raddr = ADDR_W'(scan_reg) * ADDR_W'(RUN_LENGTH) + ADDR_W'(scan_head);
    assign in_ready  = (state_reg == S_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign ram_we    = in_fire;
    assign ram_waddr = load_cnt_reg;
    assign ram_wdata = in_key;
    assign last_emit = (emit_cnt_reg == ADDR_W'(TOTAL - 1));

    assign emit.valid = (state_reg == S_EMIT);
    assign emit.last  = last_emit;
    assign emit.key   = best_key_reg;

    always_comb begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        emit_cnt_next  = emit_cnt_reg;
        scan_next      = scan_reg;
        rd_pend_next   = 1'b0;
        rd_run_next    = scan_reg;
        rd_head_next   = scan_head;
        found_next     = found_reg || take;
        best_key_next  = take ? ram_rdata   : best_key_reg;
        best_run_next  = take ? rd_run_reg  : best_run_reg;
        best_head_next = take ? rd_head_reg : best_head_reg;
        head_next      = head_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (in_fire) begin
                    if (load_cnt_reg == ADDR_W'(TOTAL - 1)) begin
                        state_next    = S_SCAN;
                        scan_next     = '0;
                        emit_cnt_next = '0;
                        found_next    = 1'b0;
                    end else begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
            end
            S_SCAN: begin
                rd_pend_next = active;
                if (scan_reg == RUN_W'(NUM_RUNS - 1)) begin
                    state_next = S_LAST;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_LAST: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    head_next[best_run_reg] = best_head_reg + 1'b1;
                    emit_cnt_next = emit_cnt_reg + 1'b1;
                    scan_next     = '0;
                    found_next    = 1'b0;
                    if (last_emit) begin
                        state_next    = S_LOAD;
                        load_cnt_next = '0;
                        emit_cnt_next = '0;
                        for (int r = 0; r < NUM_RUNS; r++) begin
                            head_next[r] = '0;
                        end
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            load_cnt_reg <= '0;
            emit_cnt_reg <= '0;
            scan_reg     <= '0;
            rd_pend_reg  <= 1'b0;
            found_reg    <= 1'b0;
            for (int r = 0; r < NUM_RUNS; r++) begin
                head_reg[r] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            emit_cnt_reg <= emit_cnt_next;
            scan_reg     <= scan_next;
            rd_pend_reg  <= rd_pend_next;
            found_reg    <= found_next;
            head_reg     <= head_next;
        end
        rd_run_reg    <= rd_run_next;
        rd_head_reg   <= rd_head_next;
        best_key_reg  <= best_key_next;
        best_run_reg  <= best_run_next;
        best_head_reg <= best_head_next;
    end

endmodule

`default_nettype wire

[sv/k_way_sorted_run_merge.sv]
// K-way merge of sorted runs: loads NUM_RUNS runs of RUN_LENGTH signed keys,
// then streams all keys out in ascending order.
// Depends on kwm_pkg, kwm_ram, kwm_seq.
//
// Usage:
//   Slave channel s_*: one signed 32-bit key per transaction, run 0 first,
//   each run assumed ascending.
//   Master channel m_*: merged keys in ascending order, ties going to the
//   lower-numbered run; m_tlast marks the last key of the merged sequence.
//   Merge: after the final key of a load, each merged key is found by one
//   comparator that walks the run heads with one read of the key store RAM
//   per run; state S_LAST settles the last compare and state S_EMIT hands the
//   key to the output register, and the scan for the next key starts after it.
//   s_tready is low for the whole merge and rises once the last key sits in
//   the output register.
//   Reset: synchronous, active low; clears the load count, run heads and
//   output valid. Key store contents are not cleared.
//   Stall: while m_tready is low the output register holds its key and the
//   merge waits before committing the next one.
`default_nettype none

module k_way_sorted_run_merge
    import kwm_pkg::*;
#(
    parameter int NUM_RUNS   = NUM_RUNS_DEF,
    parameter int RUN_LENGTH = RUN_LENGTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [KEY_W-1:0] s_tdata,   // [31:0] key
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [KEY_W-1:0] m_tdata,   // [31:0] merged_key
    output logic                  m_tlast    // final_flag
);

    localparam int TOTAL  = NUM_RUNS * RUN_LENGTH;
    localparam int ADDR_W = $clog2(TOTAL);

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [KEY_W-1:0]  ram_rdata;
    logic              out_free;
    kwm_emit_t         emit;

    logic              m_valid_reg;
    logic [KEY_W-1:0]  m_data_reg;
    logic              m_last_reg;

    kwm_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TOTAL)
    ) u_key_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kwm_seq #(
        .NUM_RUNS   (NUM_RUNS),
        .RUN_LENGTH (RUN_LENGTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_key    (s_tdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_free  (out_free),
        .emit      (emit)
    );

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit.valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (emit.valid && out_free) begin
            m_data_reg <= emit.key;
            m_last_reg <= emit.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

[sv/kwm_checker.sv]
// Port-level checker for the k-way sorted run merge, bound to the top level.
// Depends on kwm_pkg and k_way_sorted_run_merge.
`default_nettype none

module kwm_checker
    import kwm_pkg::*;
#(
    parameter int NUM_RUNS   = NUM_RUNS_DEF,
    parameter int RUN_LENGTH = RUN_LENGTH_DEF
) (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [KEY_W-1:0] m_tdata,
    input wire logic             m_tlast
);

    localparam int TOTAL = NUM_RUNS * RUN_LENGTH;
    localparam int CNT_W = $clog2(TOTAL + 1);

    logic             in_fire;
    logic             out_fire;
    logic [CNT_W-1:0] in_cnt_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
        end else begin
            if (in_fire) begin
                in_cnt_reg <= (in_cnt_reg == CNT_W'(TOTAL - 1)) ? '0 : in_cnt_reg + 1'b1;
            end
            if (out_fire) begin
                out_cnt_reg <= m_tlast ? '0 : out_cnt_reg + 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    a_no_out_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_last_position: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire |-> (m_tlast == (out_cnt_reg == CNT_W'(TOTAL - 1))))
        else $error("last flag not on the final merged key");

    a_out_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire && !m_tlast |-> in_cnt_reg == '0)
        else $error("merged key before the load completed");

    a_in_between_merges: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |-> out_cnt_reg == '0 || out_cnt_reg == CNT_W'(TOTAL - 1))
        else $error("input accepted during a merge");

endmodule

bind k_way_sorted_run_merge kwm_checker #(
    .NUM_RUNS   (NUM_RUNS),
    .RUN_LENGTH (RUN_LENGTH)
) u_kwm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
